// File: sv/hhc_pkg.sv
// ----------------------------------------------------------------------------
// hhc_pkg
// Shared types and constants of the hue color classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hhc_pkg;

    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 24;
    localparam int POS_W   = 10;
    localparam int HUE_W   = 12;
    localparam int CLS_W   = 3;
    localparam int QUOT_W  = 10;
    localparam int DIV_W   = 18;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [DIV_W-1:0] HUE_SCALE = 18'd600;
    localparam logic [HUE_W-1:0] HUE_FULL  = 12'd3600;
    localparam logic [HUE_W-1:0] HUE_GREEN = 12'd1200;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 12'd2400;
    localparam logic [HUE_W-1:0] HUE_TIE   = 12'd390;
    localparam logic [HUE_W-1:0] GREEN_LO  = 12'd850;
    localparam logic [HUE_W-1:0] GREEN_HI  = 12'd1250;
    localparam logic [HUE_W-1:0] BLUE_LO   = 12'd1950;
    localparam logic [HUE_W-1:0] BLUE_HI   = 12'd2350;

    localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLS_W-1:0] CLS_RED    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_HIGH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOL   = 3'd7;

    typedef enum logic [2:0] {
        SEL_RG,
        SEL_RB,
        SEL_GR,
        SEL_BL,
        SEL_TIE
    } hue_sel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  red_low;
        logic [HUE_W-1:0]  red_high;
        logic [HUE_W-1:0]  yellow_low;
        logic [HUE_W-1:0]  yellow_high;
        logic [HUE_W-1:0]  bg_low;
        logic [HUE_W-1:0]  bg_high;
        logic [CHAN_W-1:0] sat_limit;
        logic [CHAN_W-1:0] match_tol;
    } cfg_t;

    typedef struct packed {
        logic              uniform;
        logic [CHAN_W-1:0] sat;
        hue_sel_t          sel;
        logic              neg;
        logic [DIV_W-1:0]  rem;
        logic [CHAN_W-1:0] den;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } item_t;

endpackage
`default_nettype wire

// File: sv/hhc_front.sv
// ----------------------------------------------------------------------------
// hhc_front
// Input stage: neighbor uniformity check, hue case and divider operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hhc_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hhc_pkg::PIX_W-1:0]   centre,
    input  wire logic [hhc_pkg::PIX_W-1:0]   above,
    input  wire logic [hhc_pkg::PIX_W-1:0]   below,
    input  wire logic [hhc_pkg::PIX_W-1:0]   right_px,
    input  wire logic [hhc_pkg::PIX_W-1:0]   left_px,
    input  wire logic [hhc_pkg::POS_W-1:0]   pos_x,
    input  wire logic [hhc_pkg::POS_W-1:0]   pos_y,
    input  wire logic [hhc_pkg::CHAN_W-1:0]  match_tol,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output hhc_pkg::item_t                   out_item
);

    logic           valid_reg;
    hhc_pkg::item_t item_reg;
    hhc_pkg::item_t item_next;
    logic [2:0]     near;
    logic [7:0]     r, g, b, mx, mn, num, den;
    logic           neg;
    hhc_pkg::hue_sel_t sel;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [9:0] sum;
            logic [7:0] m, cv, d;
            sum = 10'(above[c*8 +: 8]) + 10'(below[c*8 +: 8])
                + 10'(right_px[c*8 +: 8]) + 10'(left_px[c*8 +: 8]);
            m  = sum[9:2];
            cv = centre[c*8 +: 8];
            d  = (cv > m) ? cv - m : m - cv;
            near[c] = d < match_tol;
        end
    end

    always_comb begin
        r = centre[23:16];
        g = centre[15:8];
        b = centre[7:0];
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        neg = 1'b0;
        num = '0;
        den = 8'd1;
        if (r > g && g >= b) begin
            sel = hhc_pkg::SEL_RG;
            num = g - b;
            den = r - b;
        end else if (r > g && b > g && r >= b) begin
            sel = hhc_pkg::SEL_RB;
            num = b - g;
            den = r - g;
        end else if (g > r && g > b) begin
            sel = hhc_pkg::SEL_GR;
            den = g - mn;
            neg = r > b;
            num = neg ? r - b : b - r;
        end else if (b > r && b > g) begin
            sel = hhc_pkg::SEL_BL;
            den = b - mn;
            neg = g > r;
            num = neg ? g - r : r - g;
        end else begin
            sel = hhc_pkg::SEL_TIE;
        end
        item_next.uniform = &near;
        item_next.sat     = mx - mn;
        item_next.sel     = sel;
        item_next.neg     = neg;
        item_next.rem     = hhc_pkg::DIV_W'(num) * hhc_pkg::HUE_SCALE;
        item_next.den     = den;
        item_next.x       = pos_x;
        item_next.y       = pos_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/hhc_queue.sv
// ----------------------------------------------------------------------------
// hhc_queue
// Two-entry queue between the front and back sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hhc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire hhc_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output hhc_pkg::item_t       pop_item
);

    hhc_pkg::item_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
        end
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: sv/hhc_back.sv
// ----------------------------------------------------------------------------
// hhc_back
// Bit-per-stage hue divider followed by the classification register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hhc_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire hhc_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire hhc_pkg::item_t              in_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_keep,
    output logic [hhc_pkg::CLS_W-1:0]        out_class,
    output logic [hhc_pkg::HUE_W-1:0]        out_hue,
    output logic [hhc_pkg::POS_W-1:0]        out_x,
    output logic [hhc_pkg::POS_W-1:0]        out_y
);

    localparam int NSTG = hhc_pkg::QUOT_W;

    typedef struct packed {
        hhc_pkg::item_t               it;
        logic [hhc_pkg::QUOT_W-1:0]   quot;
    } stg_t;

    stg_t stg_reg [NSTG];
    stg_t stg_in  [NSTG];
    stg_t stg_out [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_in;
    logic            out_vld_reg;
    logic            adv;

    logic                       keep_next, band;
    logic [hhc_pkg::CLS_W-1:0]  cls_next;
    logic [hhc_pkg::HUE_W-1:0]  hue_next, q12;
    hhc_pkg::item_t             last;

    logic                       keep_reg;
    logic [hhc_pkg::CLS_W-1:0]  cls_reg;
    logic [hhc_pkg::HUE_W-1:0]  hue_reg;
    logic [hhc_pkg::POS_W-1:0]  x_reg, y_reg;

    assign adv       = !out_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_vld_reg;
    assign out_keep  = keep_reg;
    assign out_class = cls_reg;
    assign out_hue   = hue_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

    for (genvar k = 0; k < NSTG; k++) begin : g_div
        localparam int BITPOS = NSTG - 1 - k;
        logic [hhc_pkg::DIV_W-1:0] trial;

        if (k == 0) begin : g_first
            assign stg_in[k] = '{it: in_item, quot: '0};
            assign vld_in[k] = in_valid;
        end else begin : g_rest
            assign stg_in[k] = stg_reg[k-1];
            assign vld_in[k] = vld_reg[k-1];
        end

        always_comb begin
            trial = hhc_pkg::DIV_W'(stg_in[k].it.den) << BITPOS;
            stg_out[k] = stg_in[k];
            if (stg_in[k].it.rem >= trial) begin
                stg_out[k].it.rem       = stg_in[k].it.rem - trial;
                stg_out[k].quot[BITPOS] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_in[k];
            end
            if (adv) begin
                stg_reg[k] <= stg_out[k];
            end
        end
    end

    always_comb begin
        last = stg_reg[NSTG-1].it;
        q12  = hhc_pkg::HUE_W'(stg_reg[NSTG-1].quot);
        unique case (last.sel)
            hhc_pkg::SEL_RG:  hue_next = q12;
            hhc_pkg::SEL_RB:  hue_next = hhc_pkg::HUE_FULL - q12;
            hhc_pkg::SEL_GR:  hue_next = last.neg ? hhc_pkg::HUE_GREEN - q12
                                                  : hhc_pkg::HUE_GREEN + q12;
            hhc_pkg::SEL_BL:  hue_next = last.neg ? hhc_pkg::HUE_BLUE - q12
                                                  : hhc_pkg::HUE_BLUE + q12;
            default:          hue_next = hhc_pkg::HUE_TIE;
        endcase
        band      = hue_next > cfg.bg_low && hue_next < cfg.bg_high;
        keep_next = last.uniform && !(band && last.sat < cfg.sat_limit);
        cls_next  = hhc_pkg::CLS_NONE;
        if (keep_next) begin
            if (hue_next > cfg.red_low || hue_next < cfg.red_high) begin
                cls_next = hhc_pkg::CLS_RED;
            end else if (hue_next > hhc_pkg::GREEN_LO && hue_next < hhc_pkg::GREEN_HI) begin
                cls_next = hhc_pkg::CLS_GREEN;
            end else if (hue_next > hhc_pkg::BLUE_LO && hue_next < hhc_pkg::BLUE_HI) begin
                cls_next = hhc_pkg::CLS_BLUE;
            end else if ((hue_next > cfg.yellow_low && hue_next < cfg.yellow_high)
                         || (band && last.sat > cfg.sat_limit)) begin
                cls_next = hhc_pkg::CLS_YELLOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[NSTG-1];
        end
        if (adv) begin
            keep_reg <= keep_next;
            cls_reg  <= cls_next;
            hue_reg  <= hue_next;
            x_reg    <= last.x;
            y_reg    <= last.y;
        end
    end

endmodule
`default_nettype wire

// File: sv/hsv_hue_color_classifier.sv
// ----------------------------------------------------------------------------
// hsv_hue_color_classifier
// Classifies a candidate pixel by hue after a neighbor uniformity check.
//
// Input stream s_*: one candidate per item (centre pixel, four neighbors,
// position). Output stream m_*: one result per item, in order.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write one threshold register
// per cycle; write only while the block holds no items.
// Path: a result shows on m_tvalid after its item passes one front register,
// one queue slot, ten divider stages and one output register. Throughput:
// one item per cycle while m_tready is high; the ten-stage restoring divider
// produces one quotient bit per stage.
// When m_tready is low the back pipeline holds; the two-entry queue and the
// front register then fill and s_tready drops.
// Reset (aresetn low, synchronous) empties all stages and restores the
// default thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hsv_hue_color_classifier (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // centre_pixel, above_pixel, below_pixel, right_pixel, left_pixel,
    // pos_x, pos_y, zero pad
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // keep, color_class, hue_tenths, out_x, out_y, zero pad
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [hhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hhc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    hhc_pkg::cfg_t  cfg_reg;
    hhc_pkg::item_t f_item, q_item;
    logic           f_valid, f_ready, q_valid, q_ready;
    logic           keep;
    logic [hhc_pkg::CLS_W-1:0] cls;
    logic [hhc_pkg::HUE_W-1:0] hue;
    logic [hhc_pkg::POS_W-1:0] ox, oy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.red_low     <= 12'd3400;
            cfg_reg.red_high    <= 12'd219;
            cfg_reg.yellow_low  <= 12'd490;
            cfg_reg.yellow_high <= 12'd700;
            cfg_reg.bg_low      <= 12'd220;
            cfg_reg.bg_high     <= 12'd489;
            cfg_reg.sat_limit   <= 8'd50;
            cfg_reg.match_tol   <= 8'd5;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hhc_pkg::CFG_RED_LOW:     cfg_reg.red_low     <= cfg_wdata;
                hhc_pkg::CFG_RED_HIGH:    cfg_reg.red_high    <= cfg_wdata;
                hhc_pkg::CFG_YELLOW_LOW:  cfg_reg.yellow_low  <= cfg_wdata;
                hhc_pkg::CFG_YELLOW_HIGH: cfg_reg.yellow_high <= cfg_wdata;
                hhc_pkg::CFG_BG_LOW:      cfg_reg.bg_low      <= cfg_wdata;
                hhc_pkg::CFG_BG_HIGH:     cfg_reg.bg_high     <= cfg_wdata;
                hhc_pkg::CFG_SAT_LIMIT:   cfg_reg.sat_limit   <= cfg_wdata[7:0];
                hhc_pkg::CFG_MATCH_TOL:   cfg_reg.match_tol   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    hhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .centre    (s_tdata[23:0]),
        .above     (s_tdata[47:24]),
        .below     (s_tdata[71:48]),
        .right_px  (s_tdata[95:72]),
        .left_px   (s_tdata[119:96]),
        .pos_x     (s_tdata[129:120]),
        .pos_y     (s_tdata[139:130]),
        .match_tol (cfg_reg.match_tol),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    hhc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    hhc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_keep  (keep),
        .out_class (cls),
        .out_hue   (hue),
        .out_x     (ox),
        .out_y     (oy)
    );

    assign m_tdata = {4'd0, oy, ox, hue, cls, keep};

endmodule
`default_nettype wire

// File: verif/tb_hsv_hue_color_classifier.sv
// ----------------------------------------------------------------------------
// tb_hsv_hue_color_classifier
// Self-checking bench for the hue color classifier: a queued stream driver
// and a result monitor compare every output item with an in-bench hue and
// class predictor, over several threshold settings and idling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_hsv_hue_color_classifier;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         cfg_wr_en;
    logic [hhc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hhc_pkg::CFG_DATA_W-1:0] cfg_wdata;

    hsv_hue_color_classifier u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    hhc_pkg::cfg_t thr;
    logic [143:0]  pending_items[$];
    logic [39:0]   expected_results[$];
    int            src_idle_pct;
    int            snk_stall_pct;
    int            errors;
    int            n_in;
    int            n_out;
    longint        cycles;
    localparam longint CYCLE_LIMIT = 400000;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [39:0] classify(logic [143:0] d);
        int r, g, b, mx, mn, hue, sat, mr, mg, mb, i;
        logic [23:0] px;
        logic keep, band;
        logic [2:0] cls;
        r = d[23:16]; g = d[15:8]; b = d[7:0];
        mr = 0; mg = 0; mb = 0;
        for (i = 1; i < 5; i++) begin
            px = d[24*i +: 24];
            mr += px[23:16]; mg += px[15:8]; mb += px[7:0];
        end
        mr /= 4; mg /= 4; mb /= 4;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sat = mx - mn;
        if (r > g && g >= b) hue = (600 * (g - b)) / (r - b);
        else if (r > g && b > g && r >= b) hue = 3600 - (600 * (b - g)) / (r - g);
        else if (g > r && g > b) hue = 1200 + (600 * (b - r)) / (g - mn);
        else if (b > r && b > g) hue = 2400 + (600 * (r - g)) / (b - mn);
        else hue = hhc_pkg::HUE_TIE;
        keep = 1'b0;
        cls = hhc_pkg::CLS_NONE;
        if ((r > mr ? r - mr : mr - r) < thr.match_tol &&
            (g > mg ? g - mg : mg - g) < thr.match_tol &&
            (b > mb ? b - mb : mb - b) < thr.match_tol) begin
            band = hue > thr.bg_low && hue < thr.bg_high;
            if (!(band && sat < thr.sat_limit)) begin
                keep = 1'b1;
                if (hue > thr.red_low || hue < thr.red_high) cls = hhc_pkg::CLS_RED;
                else if (hue > hhc_pkg::GREEN_LO && hue < hhc_pkg::GREEN_HI)
                    cls = hhc_pkg::CLS_GREEN;
                else if (hue > hhc_pkg::BLUE_LO && hue < hhc_pkg::BLUE_HI)
                    cls = hhc_pkg::CLS_BLUE;
                else if ((hue > thr.yellow_low && hue < thr.yellow_high) ||
                         (band && sat > thr.sat_limit)) cls = hhc_pkg::CLS_YELLOW;
            end
        end
        return {4'b0, d[139:130], d[129:120], 12'(hue), cls, keep};
    endfunction

    // uniform neighbors around centre, offset within +/- spread
    function automatic logic [143:0] make_item(logic [23:0] c, int spread);
        logic [143:0] d;
        int i, k, v;
        d = '0;
        d[23:0] = c;
        for (i = 1; i < 5; i++)
            for (k = 0; k < 3; k++) begin
                v = c[8*k +: 8] + $urandom_range(2*spread, 0) - spread;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                d[24*i + 8*k +: 8] = v[7:0];
            end
        d[129:120] = 10'($urandom);
        d[139:130] = 10'($urandom);
        return d;
    endfunction

    task automatic push_item(logic [143:0] d);
        pending_items.insert(pending_items.size(), d);
        expected_results.insert(expected_results.size(), classify(d));
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [hhc_pkg::CFG_IDX_W-1:0] idx,
                             logic [hhc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hhc_pkg::CFG_RED_LOW:     thr.red_low = val;
            hhc_pkg::CFG_RED_HIGH:    thr.red_high = val;
            hhc_pkg::CFG_YELLOW_LOW:  thr.yellow_low = val;
            hhc_pkg::CFG_YELLOW_HIGH: thr.yellow_high = val;
            hhc_pkg::CFG_BG_LOW:      thr.bg_low = val;
            hhc_pkg::CFG_BG_HIGH:     thr.bg_high = val;
            hhc_pkg::CFG_SAT_LIMIT:   thr.sat_limit = val[7:0];
            default:                  thr.match_tol = val[7:0];
        endcase
    endtask

    task automatic random_phase(int n);
        int i, sel;
        logic [143:0] d;
        for (i = 0; i < n; i++) begin
            sel = $urandom_range(9, 0);
            if (sel < 7) push_item(make_item(24'($urandom), $urandom_range(6, 0)));
            else if (sel < 9) begin
                d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
                push_item(d);
            end else begin
                d = make_item({8'($urandom_range(255, 0)),
                               {2{8'($urandom_range(255, 0))}}}, 1);
                push_item(d);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(pending_items.pop_front());
                n_in++;
            end
            if ((!s_tvalid || s_tready)) begin
                if (pending_items.size() > (s_tvalid && s_tready ? 1 : 0) - 1 &&
                    pending_items.size() != 0 &&
                    $urandom_range(99, 0) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_items[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= $urandom_range(99, 0) >= snk_stall_pct;
        end
    end

    always @(posedge aclk) begin
        logic [39:0] exp_r;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            n_out++;
            if (expected_results.size() == 0) begin
                $display("%0t unexpected item: expected none actual %h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[0] !== exp_r[0] || m_tdata[3:1] !== exp_r[3:1] ||
                    m_tdata[15:4] !== exp_r[15:4] || m_tdata[25:16] !== exp_r[25:16] ||
                    m_tdata[35:26] !== exp_r[35:26] || m_tdata[39:36] !== 4'b0) begin
                    $display("%0t mismatch: expected %h actual %h", $time, exp_r, m_tdata);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("hsv_hue_color_classifier verification failed");
            $finish;
        end
    end

    initial begin
        int p;
        logic [143:0] d;
        errors = 0; n_in = 0; n_out = 0; cycles = 0;
        src_idle_pct = 0; snk_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        thr = '{12'd3400, 12'd219, 12'd490, 12'd700, 12'd220, 12'd489, 8'd50, 8'd5};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each hue sector, ties, grey, band edges
        push_item('0);
        push_item({144{1'b1}});
        push_item(make_item(24'hFF0000, 0));
        push_item(make_item(24'h00FF00, 0));
        push_item(make_item(24'h0000FF, 0));
        push_item(make_item(24'hFFFF00, 0));
        push_item(make_item(24'h00FFFF, 0));
        push_item(make_item(24'hFF00FF, 0));
        push_item(make_item(24'h808080, 0));
        push_item(make_item(24'hFF8000, 0));
        push_item(make_item(24'hC0A040, 0));
        push_item(make_item(24'h604E40, 0));
        push_item(make_item(24'h605030, 0));
        push_item(make_item(24'h40C080, 0));
        push_item(make_item(24'h4080C0, 0));
        push_item(make_item(24'h8040C0, 0));
        push_item(make_item(24'hC04080, 0));
        push_item(make_item(24'h80FF80, 4));
        push_item(make_item(24'h80FF80, 5));
        d = make_item(24'h102030, 0);
        d[47:24] = 24'h142030;
        push_item(d);
        drain();

        for (p = 0; p < 6; p++) begin
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            case (p)
                1: begin
                    write_reg(hhc_pkg::CFG_RED_LOW, 12'd0);
                    write_reg(hhc_pkg::CFG_RED_HIGH, 12'd0);
                    write_reg(hhc_pkg::CFG_SAT_LIMIT, 12'd255);
                    write_reg(hhc_pkg::CFG_MATCH_TOL, 12'd255);
                end
                2: begin
                    write_reg(hhc_pkg::CFG_RED_LOW, 12'hFFF);
                    write_reg(hhc_pkg::CFG_RED_HIGH, 12'd3600);
                    write_reg(hhc_pkg::CFG_YELLOW_LOW, 12'd0);
                    write_reg(hhc_pkg::CFG_YELLOW_HIGH, 12'hFFF);
                    write_reg(hhc_pkg::CFG_BG_LOW, 12'd0);
                    write_reg(hhc_pkg::CFG_BG_HIGH, 12'd3600);
                    write_reg(hhc_pkg::CFG_SAT_LIMIT, 12'd0);
                    write_reg(hhc_pkg::CFG_MATCH_TOL, 12'd0);
                end
                3, 4, 5: begin
                    write_reg(hhc_pkg::CFG_RED_LOW, 12'($urandom_range(3600, 2800)));
                    write_reg(hhc_pkg::CFG_RED_HIGH, 12'($urandom_range(400, 0)));
                    write_reg(hhc_pkg::CFG_YELLOW_LOW, 12'($urandom_range(600, 300)));
                    write_reg(hhc_pkg::CFG_YELLOW_HIGH, 12'($urandom_range(900, 600)));
                    write_reg(hhc_pkg::CFG_BG_LOW, 12'($urandom_range(400, 0)));
                    write_reg(hhc_pkg::CFG_BG_HIGH, 12'($urandom_range(800, 300)));
                    write_reg(hhc_pkg::CFG_SAT_LIMIT, 12'($urandom_range(255, 0)));
                    write_reg(hhc_pkg::CFG_MATCH_TOL, 12'($urandom_range(12, 1)));
                end
                default: ;
            endcase
            random_phase(125);
            // hold off until the pipe is empty, then continue
            drain();
            random_phase(125);
            drain();
        end

        $display("covered %0d items in, %0d results out over six threshold settings",
                 n_in, n_out);
        $display("idling phases: none, source 45%%, sink 45%%, both 9%%");
        if (errors == 0)
            $display("hsv_hue_color_classifier verification clean");
        else
            $display("hsv_hue_color_classifier verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/hhc_pkg.sv
sv/hhc_front.sv
sv/hhc_queue.sv
sv/hhc_back.sv
sv/hsv_hue_color_classifier.sv
verif/tb_hsv_hue_color_classifier.sv
